// ===== rtl/core/mbc1_pkg.sv =====
// mbc1_pkg: shared sizes, codes and controller/datapath handshake types
// for the mbc1 cartridge bank mapper; no dependencies
package mbc1_pkg;

   localparam int ROM_BANKS      = 32;
   localparam int RAM_BANKS      = 4;
   localparam int ROM_OFF_W      = 14;
   localparam int RAM_OFF_W      = 13;
   localparam int ROM_BANK_BYTES = 1 << ROM_OFF_W;
   localparam int RAM_BANK_BYTES = 1 << RAM_OFF_W;
   localparam int ROM_DEPTH      = ROM_BANKS * ROM_BANK_BYTES;
   localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
   localparam int ROM_AW         = $clog2(ROM_DEPTH);
   localparam int RAM_AW         = $clog2(RAM_DEPTH);
   localparam int ROM_SZ_W       = ROM_AW + 1;
   localparam int RAM_SZ_W       = RAM_AW + 1;
   localparam int ROM_CNT_W      = $clog2(ROM_BANKS + 1);
   localparam int RAM_CNT_W      = $clog2(RAM_BANKS + 1);

   localparam int CMD_W       = 2;
   localparam int ADDR_W      = 16;
   localparam int IDX_W       = 19;
   localparam int DATA_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int ROM_BYTES_W = 20;
   localparam int RAM_BYTES_W = 16;

   localparam int BANK_LO_W = 5;
   localparam int BANK_HI_W = 2;
   localparam int BANK_W    = BANK_LO_W + BANK_HI_W;
   localparam int MOD_STEPS = BANK_W;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   localparam logic [DATA_W-1:0] OPEN_BUS   = 8'hFF;
   localparam logic [3:0]        RAM_EN_KEY = 4'hA;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LOAD  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAPPER_KIND = 2'd0,
      CSR_ROM_BYTES   = 2'd1,
      CSR_RAM_BYTES   = 2'd2
   } csr_index_type;

   // control register window, selected by bus address bits 14:13
   typedef enum logic [1:0] {
      REG_RAM_EN  = 2'd0,
      REG_BANK_LO = 2'd1,
      REG_BANK_HI = 2'd2,
      REG_MODE    = 2'd3
   } mbc_reg_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic mod_start;
      logic mod_step;
      logic fetch;
      logic load_out;
      logic clear_en;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic need_mod;
      logic clear_done;
   } ctl_sts_type;

endpackage

// ===== rtl/core/mbc1_cartridge_bank_mapper.sv =====
// mbc1_cartridge_bank_mapper: top level of the cartridge bank mapper
// depends on mbc1_pkg, mbc1_ctrl, mbc1_dp (and mbc1_ram below it)
//
// Serves bus reads, bus writes and rom load bytes one transaction at a time.
// After reset the cartridge ram is swept to zero, one byte a cycle, through all of
// its bytes; req_stall stays high meanwhile, size registers may still be written.
// A write or a load is committed straight after decode. A read is fetched from the
// stores and then loaded into the output; when it addresses the rom window in mbc1
// mode with a cartridge present, a 7-step bank modulo unit first reduces the bank
// number modulo the rom bank count before the rom is addressed. The result sits
// in an output register, so the next transaction is taken while it waits.
module mbc1_cartridge_bank_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mbc1_pkg::CMD_W-1:0]      req_cmd,
   input  logic [mbc1_pkg::ADDR_W-1:0]     req_bus_address,
   input  logic [mbc1_pkg::IDX_W-1:0]      req_rom_index,
   input  logic [mbc1_pkg::DATA_W-1:0]     req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mbc1_pkg::DATA_W-1:0]     rsp_read_data,
   input  logic                            csr_wr_en,
   input  logic [mbc1_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbc1_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mbc1_pkg::*;

   ctl_cmd_type ctl;
   ctl_sts_type sts;

   mbc1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   mbc1_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_bus_address (req_bus_address),
      .req_rom_index   (req_rom_index),
      .req_data        (req_data),
      .rsp_read_data   (rsp_read_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .ctl             (ctl),
      .sts             (sts)
   );

endmodule

// ===== rtl/core/mbc1_ram.sv =====
// mbc1_ram: generic single-port ram with registered read
// no dependencies
module mbc1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/mbc1_ctrl.sv =====
// mbc1_ctrl: sequencing state machine for the bank mapper
// depends on mbc1_pkg
module mbc1_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mbc1_pkg::ctl_sts_type sts,
   output mbc1_pkg::ctl_cmd_type ctl
);
   import mbc1_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_MOD,
      S_FETCH,
      S_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ctl          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.is_read) begin
               ctl.commit = 1'b1;
               state_in   = S_IDLE;
            end else if (sts.need_mod) begin
               ctl.mod_start = 1'b1;
               step_in       = '0;
               state_in      = S_MOD;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_MOD: begin
            ctl.mod_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            ctl.fetch = 1'b1;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               ctl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/mbc1_dp.sv =====
// mbc1_dp: transaction registers, control and size registers, bank modulo
// unit, address decode and the rom and ram stores; depends on mbc1_pkg, mbc1_ram
module mbc1_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mbc1_pkg::CMD_W-1:0]       req_cmd,
   input  logic [mbc1_pkg::ADDR_W-1:0]      req_bus_address,
   input  logic [mbc1_pkg::IDX_W-1:0]       req_rom_index,
   input  logic [mbc1_pkg::DATA_W-1:0]      req_data,
   output logic [mbc1_pkg::DATA_W-1:0]      rsp_read_data,
   input  logic                             csr_wr_en,
   input  logic [mbc1_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbc1_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  mbc1_pkg::ctl_cmd_type            ctl,
   output mbc1_pkg::ctl_sts_type            sts
);
   import mbc1_pkg::*;

   // transaction registers
   logic [CMD_W-1:0]  cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] data_ff;

   // size registers
   logic                 kind_ff;
   logic [ROM_SZ_W-1:0]  rom_sat_ff, rom_sat_in;
   logic [RAM_SZ_W-1:0]  ram_sat_ff, ram_sat_in;
   logic [ROM_CNT_W-1:0] rom_cnt_ff, rom_cnt_in;
   logic [RAM_CNT_W-1:0] ram_cnt_ff, ram_cnt_in;
   logic [ROM_SZ_W:0]    rom_cnt_sum;
   logic [RAM_SZ_W:0]    ram_cnt_sum;
   logic [RAM_BYTES_W-1:0] ram_bytes_v;

   // mbc1 control registers
   logic                 ram_en_ff;
   logic [BANK_LO_W-1:0] bank_lo_ff;
   logic [BANK_HI_W-1:0] bank_hi_ff;
   logic                 mode_ff;

   // bank modulo unit
   logic [BANK_W-1:0]    mod_bank_ff, mod_bank_in;
   logic [ROM_CNT_W-1:0] rem_ff, rem_in;
   logic [ROM_CNT_W:0]   trial;
   logic [BANK_LO_W-1:0] low_eff;

   // decode
   logic                 rom_present;
   logic [ROM_SZ_W-1:0]  rom_pos;
   logic                 rom_hit;
   logic [2:0]           ram_bank3, ram_cnt3, ram_mod3;
   logic [RAM_SZ_W-1:0]  ram_pos;
   logic                 ram_win;
   logic                 ram_hit;
   logic                 load_ok;
   logic                 rom_hit_ff, ram_hit_ff;
   logic [RAM_AW-1:0]    clr_addr_ff;
   logic [DATA_W-1:0]    out_ff;

   // store ports
   logic                 rom_we;
   logic [ROM_AW-1:0]    rom_addr;
   logic [DATA_W-1:0]    rom_q;
   logic                 ram_we;
   logic [RAM_AW-1:0]    ram_addr;
   logic [DATA_W-1:0]    ram_wdata;
   logic [DATA_W-1:0]    ram_q;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         addr_ff <= req_bus_address;
         idx_ff  <= req_rom_index;
         data_ff <= req_data;
      end
   end

   // size registers saturate at the store depth; bank counts round up
   always_comb begin
      if (32'(csr_wdata) > ROM_DEPTH) begin
         rom_sat_in = ROM_SZ_W'(ROM_DEPTH);
      end else begin
         rom_sat_in = ROM_SZ_W'(csr_wdata);
      end
      ram_bytes_v = csr_wdata[RAM_BYTES_W-1:0];
      if (32'(ram_bytes_v) > RAM_DEPTH) begin
         ram_sat_in = RAM_SZ_W'(RAM_DEPTH);
      end else begin
         ram_sat_in = RAM_SZ_W'(ram_bytes_v);
      end
      rom_cnt_sum = {1'b0, rom_sat_in} + (ROM_SZ_W + 1)'(ROM_BANK_BYTES - 1);
      ram_cnt_sum = {1'b0, ram_sat_in} + (RAM_SZ_W + 1)'(RAM_BANK_BYTES - 1);
      rom_cnt_in  = ROM_CNT_W'(rom_cnt_sum >> ROM_OFF_W);
      ram_cnt_in  = RAM_CNT_W'(ram_cnt_sum >> RAM_OFF_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= 1'b0;
         rom_sat_ff <= '0;
         ram_sat_ff <= '0;
         rom_cnt_ff <= '0;
         ram_cnt_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAPPER_KIND: kind_ff <= csr_wdata[0];
            CSR_ROM_BYTES: begin
               rom_sat_ff <= rom_sat_in;
               rom_cnt_ff <= rom_cnt_in;
            end
            CSR_RAM_BYTES: begin
               ram_sat_ff <= ram_sat_in;
               ram_cnt_ff <= ram_cnt_in;
            end
            default: ;
         endcase
      end
   end

   assign rom_present = (rom_sat_ff != '0);

   // ram window decode
   assign ram_win   = (addr_ff[15:13] == 3'b101);
   assign ram_bank3 = mode_ff ? 3'(bank_hi_ff) : 3'd0;
   assign ram_cnt3  = 3'(ram_cnt_ff);
   always_comb begin
      if (ram_cnt3 <= 3'd1) begin
         ram_mod3 = 3'd0;
      end else if (ram_bank3 >= ram_cnt3) begin
         ram_mod3 = ram_bank3 - ram_cnt3;
      end else begin
         ram_mod3 = ram_bank3;
      end
   end
   assign ram_pos = (RAM_SZ_W'(ram_mod3) << RAM_OFF_W) | RAM_SZ_W'(addr_ff[RAM_OFF_W-1:0]);
   assign ram_hit = rom_present && kind_ff && ram_en_ff && (ram_sat_ff != '0) && ram_win
                    && (ram_pos < ram_sat_ff);

   // mbc1 control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ram_en_ff  <= 1'b0;
         bank_lo_ff <= BANK_LO_W'(1);
         bank_hi_ff <= '0;
         mode_ff    <= 1'b0;
      end else if (ctl.commit && cmd_ff == CMD_WRITE && rom_present && kind_ff
                   && !addr_ff[15]) begin
         case (mbc_reg_type'(addr_ff[14:13]))
            REG_RAM_EN:  ram_en_ff  <= (data_ff[3:0] == RAM_EN_KEY);
            REG_BANK_LO: bank_lo_ff <= data_ff[BANK_LO_W-1:0];
            REG_BANK_HI: bank_hi_ff <= data_ff[BANK_HI_W-1:0];
            REG_MODE:    mode_ff    <= data_ff[0];
            default: ;
         endcase
      end
   end

   // bank modulo: restoring remainder, one bank bit a cycle
   assign low_eff = (bank_lo_ff == '0) ? BANK_LO_W'(1) : bank_lo_ff;
   assign trial   = {rem_ff, mod_bank_ff[BANK_W-1]};

   always_comb begin
      mod_bank_in = mod_bank_ff;
      rem_in      = rem_ff;
      if (ctl.mod_start) begin
         rem_in = '0;
         if (!addr_ff[14]) begin
            mod_bank_in = mode_ff ? {bank_hi_ff, BANK_LO_W'(0)} : '0;
         end else begin
            mod_bank_in = {bank_hi_ff, low_eff};
         end
      end else if (ctl.mod_step) begin
         mod_bank_in = mod_bank_ff << 1;
         if (trial >= {1'b0, rom_cnt_ff}) begin
            rem_in = ROM_CNT_W'(trial - {1'b0, rom_cnt_ff});
         end else begin
            rem_in = trial[ROM_CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      mod_bank_ff <= mod_bank_in;
      rem_ff      <= rem_in;
   end

   // rom decode
   always_comb begin
      if (kind_ff) begin
         rom_pos = (ROM_SZ_W'(rem_ff) << ROM_OFF_W) | ROM_SZ_W'(addr_ff[ROM_OFF_W-1:0]);
      end else begin
         rom_pos = ROM_SZ_W'(addr_ff[14:0]);
      end
   end
   assign rom_hit = rom_present && !addr_ff[15] && (rom_pos < rom_sat_ff);
   assign load_ok = (32'(idx_ff) < ROM_DEPTH);

   assign rom_we   = ctl.commit && (cmd_ff == CMD_LOAD) && load_ok;
   assign rom_addr = rom_we ? ROM_AW'(idx_ff) : rom_pos[ROM_AW-1:0];

   // ram port: clearing pass after reset, then bus accesses
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (ctl.clear_en) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign ram_we    = ctl.clear_en || (ctl.commit && cmd_ff == CMD_WRITE && ram_hit);
   assign ram_addr  = ctl.clear_en ? clr_addr_ff : ram_pos[RAM_AW-1:0];
   assign ram_wdata = ctl.clear_en ? '0 : data_ff;

   mbc1_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ROM_DEPTH)
   ) u_rom (
      .clock (clock),
      .we    (rom_we),
      .re    (ctl.fetch),
      .addr  (rom_addr),
      .wdata (data_ff),
      .rdata (rom_q)
   );

   mbc1_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ctl.fetch),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_q)
   );

   // result path
   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         rom_hit_ff <= rom_hit;
         ram_hit_ff <= ram_hit;
      end
      if (ctl.load_out) begin
         if (rom_hit_ff) begin
            out_ff <= rom_q;
         end else if (ram_hit_ff) begin
            out_ff <= ram_q;
         end else begin
            out_ff <= OPEN_BUS;
         end
      end
   end

   assign rsp_read_data  = out_ff;
   assign sts.is_read    = (cmd_ff == CMD_READ);
   assign sts.need_mod   = kind_ff && rom_present && !addr_ff[15];
   assign sts.clear_done = (clr_addr_ff == RAM_AW'(RAM_DEPTH - 1));

endmodule

// ===== rtl/core/mbc1_checker.sv =====
// mbc1_checker: port-level checks on the bank mapper, bound to the top level
// depends on mbc1_pkg
module mbc1_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [mbc1_pkg::DATA_W-1:0]     rsp_read_data
);
   import mbc1_pkg::*;

   // ram clearing pass holds off transactions right after reset
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("transaction path open right after reset");

   // one transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while one is in flight");

   // a fresh result only appears as the block finishes a read
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while the block was idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result dropped or changed");

endmodule

bind mbc1_cartridge_bank_mapper mbc1_checker u_mbc1_checker (.*);

// ===== sim/tb.sv =====
// tb: self-checking testbench for mbc1_cartridge_bank_mapper, with its own model of
// the mapper, the rom and ram images in a scoreboard class
// depends on mbc1_pkg and the mapper rtl
module tb;
   import mbc1_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int PHASES = 8;
   localparam bit          KIND_CFG [PHASES] = '{0, 1, 1, 1, 0, 1, 1, 1};
   localparam bit [19:0]   ROM_CFG  [PHASES] = '{20'h08000, 20'hFFFFF, 20'h04001, 20'h20000,
                                                 20'h01234, 20'h80000, 20'h00001, 20'h00000};
   localparam bit [15:0]   RAM_CFG  [PHASES] = '{16'h0000, 16'hFFFF, 16'h1001, 16'h2000,
                                                 16'h8000, 16'h8000, 16'h0001, 16'h8000};

   typedef enum logic [1:0] {HIT_NONE, HIT_ROM, HIT_RAM} hit_type;

   class mapper_scoreboard;
      bit          mbc1_on;
      int unsigned rom_size;
      int unsigned ram_size;
      bit          ram_on;
      bit [4:0]    bank_lo;
      bit [1:0]    bank_hi;
      bit          mode;
      bit [7:0]    rom_img [ROM_DEPTH];
      bit          rom_set [ROM_DEPTH];
      bit [7:0]    ram_img [RAM_DEPTH];
      bit [7:0]    read_q [$];
      int          errors;

      function new();
         bank_lo = 5'd1;
      endfunction

      function int pending();
         return read_q.size();
      endfunction

      function void apply_csr(csr_index_type sel, bit [19:0] value);
         case (sel)
            CSR_MAPPER_KIND: mbc1_on = value[0];
            CSR_ROM_BYTES:   rom_size = (value > ROM_DEPTH) ? ROM_DEPTH : value;
            CSR_RAM_BYTES:   ram_size = (value[15:0] > RAM_DEPTH) ? RAM_DEPTH : value[15:0];
            default: ;
         endcase
      endfunction

      // where a bus address lands under the current banking
      function hit_type locate(bit [15:0] addr, output int unsigned pos);
         int unsigned banks;
         int unsigned bank;
         pos = 0;
         if (rom_size == 0) return HIT_NONE;
         if (addr <= 16'h7FFF) begin
            if (!mbc1_on) begin
               pos = addr;
               return (pos < rom_size) ? HIT_ROM : HIT_NONE;
            end
            banks = (rom_size + ROM_BANK_BYTES - 1) / ROM_BANK_BYTES;
            if (!addr[14]) bank = mode ? {bank_hi, 5'd0} : 0;
            else bank = {bank_hi, (bank_lo == 5'd0) ? 5'd1 : bank_lo};
            pos = (bank % banks) * ROM_BANK_BYTES + addr[13:0];
            return (pos < rom_size) ? HIT_ROM : HIT_NONE;
         end
         if (addr[15:13] != 3'b101 || !mbc1_on || !ram_on || ram_size == 0) return HIT_NONE;
         banks = (ram_size + RAM_BANK_BYTES - 1) / RAM_BANK_BYTES;
         bank = mode ? bank_hi : 0;
         pos = (bank % banks) * RAM_BANK_BYTES + addr[12:0];
         return (pos < ram_size) ? HIT_RAM : HIT_NONE;
      endfunction

      function bit rom_gap(bit [15:0] addr, output int unsigned pos);
         return locate(addr, pos) == HIT_ROM && !rom_set[pos];
      endfunction

      function void write_bus(bit [15:0] addr, bit [7:0] data);
         int unsigned pos;
         if (rom_size == 0) return;
         if (addr <= 16'h7FFF) begin
            if (!mbc1_on) return;
            case (mbc_reg_type'(addr[14:13]))
               REG_RAM_EN:  ram_on = (data[3:0] == RAM_EN_KEY);
               REG_BANK_LO: bank_lo = data[4:0];
               REG_BANK_HI: bank_hi = data[1:0];
               REG_MODE:    mode = data[0];
               default: ;
            endcase
         end else if (locate(addr, pos) == HIT_RAM) begin
            ram_img[pos] = data;
         end
      endfunction

      function void note_request(bit [1:0] cmd, bit [15:0] addr, bit [18:0] idx,
                                 bit [7:0] data);
         int unsigned pos;
         hit_type hit;
         bit [7:0] rd_byte;
         case (cmd)
            CMD_READ: begin
               hit = locate(addr, pos);
               rd_byte = (hit == HIT_ROM) ? rom_img[pos] :
                         (hit == HIT_RAM) ? ram_img[pos] : OPEN_BUS;
               read_q = {read_q, rd_byte};
            end
            CMD_WRITE: write_bus(addr, data);
            CMD_LOAD: begin
               if (idx < ROM_DEPTH) begin
                  rom_img[idx] = data;
                  rom_set[idx] = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_read(logic [7:0] got);
         bit [7:0] want;
         if (read_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("read result with none expected: got %02h", got);
            return;
         end
         want = read_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("read data mismatch: expected %02h, got %02h", want, got);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CMD_W-1:0]  req_cmd = '0;
   logic [ADDR_W-1:0] req_bus_address = '0;
   logic [IDX_W-1:0]  req_rom_index = '0;
   logic [DATA_W-1:0] req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_read_data;
   logic              csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mapper_scoreboard sb;
   int          send_idle = 0;
   int          stall_pct = 0;
   int unsigned cycles = 0;

   mbc1_cartridge_bank_mapper DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_bus_address (req_bus_address),
      .req_rom_index   (req_rom_index),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_cmd, req_bus_address, req_rom_index, req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_read(rsp_read_data);
      end
   end

   function automatic bit [13:0] rom_offset();
      case ($urandom_range(7))
         0: return 14'h0000;
         1: return 14'h0001;
         2: return 14'h0002;
         3: return 14'h3FFF;
         4: return 14'h3FFE;
         5: return 14'h0100;
         default: return 14'($urandom);
      endcase
   endfunction

   function automatic bit [12:0] ram_offset();
      case ($urandom_range(6))
         0: return 13'h0000;
         1: return 13'h0001;
         2: return 13'h1FFF;
         3: return 13'h1000;
         4: return 13'h1001;
         default: return 13'($urandom);
      endcase
   endfunction

   function automatic bit [15:0] unmapped_address();
      if ($urandom_range(1) == 0) return {3'b100, 13'($urandom)};
      return {2'b11, 14'($urandom)};
   endfunction

   task automatic send(bit [1:0] cmd, bit [15:0] addr, bit [18:0] idx, bit [7:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_bus_address <= addr;
      req_rom_index   <= idx;
      req_data        <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // a read that would reach an unloaded rom byte gets that byte loaded first
   task automatic read_bus(bit [15:0] addr);
      int unsigned pos;
      if (sb.rom_gap(addr, pos)) send(CMD_LOAD, 16'($urandom), pos[18:0], 8'($urandom));
      send(CMD_READ, addr, 19'($urandom), 8'($urandom));
   endtask

   task automatic write_csr(csr_index_type sel, bit [19:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      sb.apply_csr(sel, value);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic random_items(int count);
      int unsigned pick;
      bit [15:0] addr;
      bit [7:0]  data;
      repeat (count) begin
         pick = $urandom_range(99);
         data = 8'($urandom);
         if (pick < 35) begin
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5, 6, 7:          addr = {2'b00, rom_offset()};
               8, 9, 10, 11, 12, 13, 14, 15:    addr = {2'b01, rom_offset()};
               16, 17, 18:                      addr = {3'b101, ram_offset()};
               default:                         addr = unmapped_address();
            endcase
            read_bus(addr);
         end else if (pick < 60) begin
            addr = 16'($urandom_range(16'h7FFF));
            if ($urandom_range(2) == 0) data[3:0] = RAM_EN_KEY;
            send(CMD_WRITE, addr, 19'($urandom), data);
         end else if (pick < 78) begin
            send(CMD_WRITE, {3'b101, ram_offset()}, 19'($urandom), data);
         end else if (pick < 92) begin
            send(CMD_LOAD, 16'($urandom), {5'($urandom), rom_offset()}, data);
         end else if (pick < 96) begin
            send(CMD_UNUSED, 16'($urandom), 19'($urandom), data);
         end else begin
            send(CMD_WRITE, unmapped_address(), 19'($urandom), data);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no cartridge: loads still stored, everything else reads open bus
      send(CMD_LOAD, 16'h0000, 19'h7FFFF, 8'hFF);
      send(CMD_LOAD, 16'hFFFF, 19'h00000, 8'h00);
      read_bus(16'h0000);
      read_bus(16'hA000);
      send(CMD_WRITE, 16'h0000, 19'h0, 8'h0A);
      send(CMD_UNUSED, 16'hFFFF, 19'h7FFFF, 8'hFF);
      random_items(40);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_csr(CSR_MAPPER_KIND, 20'(KIND_CFG[p]));
         write_csr(CSR_ROM_BYTES, ROM_CFG[p]);
         write_csr(CSR_RAM_BYTES, RAM_CFG[p]);
         csr_wr_en <= 1'b0;
         case ((p + 1) % 4)
            0: begin send_idle = 0;  stall_pct = 0;  end
            1: begin send_idle = 46; stall_pct = 0;  end
            2: begin send_idle = 0;  stall_pct = 46; end
            default: begin send_idle = 37; stall_pct = 37; end
         endcase
         if (p == 0) begin
            // plain rom: control writes and the ram window do nothing
            read_bus(16'h7FFF);
            send(CMD_WRITE, 16'h2000, 19'h0, 8'h05);
            read_bus(16'h4000);
            send(CMD_WRITE, 16'hA000, 19'h0, 8'h77);
            read_bus(16'hA000);
         end else if (p == 1) begin
            send(CMD_WRITE, 16'h1000, 19'h0, 8'h3A);
            send(CMD_WRITE, 16'h2000, 19'h0, 8'hE0);
            read_bus(16'h4000);
            send(CMD_WRITE, 16'h5FFF, 19'h0, 8'hFF);
            send(CMD_WRITE, 16'h7FFF, 19'h0, 8'hFF);
            read_bus(16'h3FFF);
            send(CMD_WRITE, 16'hBFFF, 19'h0, 8'h5A);
            read_bus(16'hBFFF);
            read_bus(16'h9FFF);
            read_bus(16'hFFFF);
            send(CMD_WRITE, 16'h1FFF, 19'h0, 8'h0B);
            read_bus(16'hBFFF);
         end
         random_items(58);
      end

      settle();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
